// ===== hdl/gdbo_pkg.sv =====
package gdbo_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int FW = 6;

    localparam logic [1:0] REQ_EDGE = 2'd0;
    localparam logic [1:0] REQ_DFS  = 2'd1;
    localparam logic [1:0] REQ_BFS  = 2'd2;

    typedef logic [MAX_VERTICES-1:0] t_row;
    typedef logic [VW-1:0]           t_vidx;
    typedef logic [CW-1:0]           t_cnt;

    typedef struct packed {
        logic  found;
        t_vidx idx;
    } t_pick;

    function automatic t_pick lowest_set(input t_row bits);
        t_pick p;
        p.found = 1'b0;
        p.idx   = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (bits[i]) begin
                p.found = 1'b1;
                p.idx   = VW'(i);
            end
        end
        return p;
    endfunction

endpackage

// ===== hdl/graph_dfs_bfs_order.sv =====
// edge add: accepted when busy is low, busy while the row is written, no results
// run: one beat per visited vertex, start vertex first; o_is_last flags the final beat
// depth-first: each stack step is one store read, one row read, one search
// breadth-first: store read, row read, a search per found vertex; receiver cannot stall
// sync reset: adjacency rows read as empty via per-row valid flags, num_vertices = 32
module graph_dfs_bfs_order (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_req_type,
    input  logic [gdbo_pkg::FW-1:0] i_from_vertex,
    input  logic [gdbo_pkg::FW-1:0] i_to_vertex,
    output logic                  o_strobe,
    output logic [gdbo_pkg::FW-1:0] o_vertex_out,
    output logic                  o_is_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [gdbo_pkg::FW-1:0] i_cfg_num_vertices
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EDGE   = 3'd1;
    localparam logic [2:0] S_D_RD   = 3'd2;
    localparam logic [2:0] S_D_TOP  = 3'd3;
    localparam logic [2:0] S_D_ROW  = 3'd4;
    localparam logic [2:0] S_B_POP  = 3'd5;
    localparam logic [2:0] S_B_ELEM = 3'd6;
    localparam logic [2:0] S_B_SCAN = 3'd7;

    localparam int MV = gdbo_pkg::MAX_VERTICES;
    localparam int VW = gdbo_pkg::VW;
    localparam int CW = gdbo_pkg::CW;
    localparam int FW = gdbo_pkg::FW;
    localparam int NW = (CW > FW) ? CW + 1 : FW + 1;

    gdbo_pkg::t_row  r_adj [MV];
    gdbo_pkg::t_vidx r_st  [MV];
    gdbo_pkg::t_row  r_row_ok;

    logic [2:0]      r_state, n_state;
    logic [FW-1:0]   r_num;
    gdbo_pkg::t_row  r_visited, n_visited;
    gdbo_pkg::t_vidx r_pend, n_pend;
    gdbo_pkg::t_vidx r_from, n_from;
    gdbo_pkg::t_vidx r_to, n_to;
    gdbo_pkg::t_cnt  r_cnt, n_cnt;
    gdbo_pkg::t_cnt  r_sp, n_sp;
    gdbo_pkg::t_cnt  r_head, n_head;
    gdbo_pkg::t_cnt  r_tail, n_tail;
    logic            r_strobe, n_strobe;
    logic            r_last, n_last;
    gdbo_pkg::t_vidx r_vout, n_vout;

    gdbo_pkg::t_row  r_adj_q;
    logic            r_adj_ok;
    gdbo_pkg::t_vidx r_st_q;

    logic            st_we, st_re, adj_we, adj_re;
    gdbo_pkg::t_vidx st_waddr, st_wdata, st_raddr, adj_raddr, adj_waddr;
    gdbo_pkg::t_row  adj_wdata, adj_row, mask, cand;
    gdbo_pkg::t_pick pick;
    logic [NW-1:0]   n_eff, from_x, to_x;

    always_comb begin
        if (r_num == '0) begin
            n_eff = NW'(1);
        end else if (NW'(r_num) > NW'(MV)) begin
            n_eff = NW'(MV);
        end else begin
            n_eff = NW'(r_num);
        end
        for (int i = 0; i < MV; i++) begin
            mask[i] = (NW'(i) < n_eff);
        end
    end

    assign from_x  = NW'(i_from_vertex);
    assign to_x    = NW'(i_to_vertex);
    assign adj_row = r_adj_ok ? r_adj_q : '0;
    assign cand    = adj_row & mask & ~r_visited;
    assign pick    = gdbo_pkg::lowest_set(cand);

    always_comb begin
        n_state   = r_state;
        n_visited = r_visited;
        n_pend    = r_pend;
        n_from    = r_from;
        n_to      = r_to;
        n_cnt     = r_cnt;
        n_sp      = r_sp;
        n_head    = r_head;
        n_tail    = r_tail;
        n_strobe  = 1'b0;
        n_last    = 1'b0;
        n_vout    = r_vout;
        st_we     = 1'b0;
        st_waddr  = '0;
        st_wdata  = '0;
        st_re     = 1'b0;
        st_raddr  = '0;
        adj_re    = 1'b0;
        adj_raddr = '0;
        adj_we    = 1'b0;
        adj_waddr = '0;
        adj_wdata = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_req_type)
                        gdbo_pkg::REQ_EDGE: begin
                            if (from_x >= NW'(1) && from_x <= n_eff &&
                                to_x >= NW'(1) && to_x <= n_eff) begin
                                adj_re    = 1'b1;
                                adj_raddr = VW'(i_from_vertex - FW'(1));
                                n_from    = VW'(i_from_vertex - FW'(1));
                                n_to      = VW'(i_to_vertex - FW'(1));
                                n_state   = S_EDGE;
                            end
                        end
                        gdbo_pkg::REQ_DFS, gdbo_pkg::REQ_BFS: begin
                            n_visited = gdbo_pkg::t_row'(1);
                            n_pend    = '0;
                            n_cnt     = CW'(1);
                            st_we     = 1'b1;
                            st_waddr  = '0;
                            st_wdata  = '0;
                            n_sp      = CW'(1);
                            n_head    = '0;
                            n_tail    = CW'(1);
                            n_state   = (i_req_type == gdbo_pkg::REQ_DFS) ? S_D_RD : S_B_POP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EDGE: begin
                adj_we    = 1'b1;
                adj_waddr = r_from;
                adj_wdata = adj_row | (gdbo_pkg::t_row'(1) << r_to);
                n_state   = S_IDLE;
            end
            S_D_RD: begin
                st_re    = 1'b1;
                st_raddr = VW'(r_sp - CW'(1));
                n_state  = S_D_TOP;
            end
            S_D_TOP: begin
                adj_re    = 1'b1;
                adj_raddr = r_st_q;
                n_state   = S_D_ROW;
            end
            S_D_ROW: begin
                if (!pick.found) begin
                    if (r_sp == CW'(1)) begin
                        n_sp     = '0;
                        n_strobe = 1'b1;
                        n_vout   = r_pend;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_sp    = r_sp - CW'(1);
                        n_state = S_D_RD;
                    end
                end else if (r_cnt < CW'(MV) && r_sp < CW'(MV)) begin
                    n_visited = r_visited | (gdbo_pkg::t_row'(1) << pick.idx);
                    n_strobe  = 1'b1;
                    n_vout    = r_pend;
                    n_pend    = pick.idx;
                    n_cnt     = r_cnt + CW'(1);
                    st_we     = 1'b1;
                    st_waddr  = r_sp[VW-1:0];
                    st_wdata  = pick.idx;
                    n_sp      = r_sp + CW'(1);
                    n_state   = S_D_RD;
                end else begin
                    n_sp     = '0;
                    n_strobe = 1'b1;
                    n_vout   = r_pend;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_B_POP: begin
                if (r_head < r_tail) begin
                    st_re    = 1'b1;
                    st_raddr = r_head[VW-1:0];
                    n_head   = r_head + CW'(1);
                    n_state  = S_B_ELEM;
                end else begin
                    n_strobe = 1'b1;
                    n_vout   = r_pend;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_B_ELEM: begin
                adj_re    = 1'b1;
                adj_raddr = r_st_q;
                n_state   = S_B_SCAN;
            end
            S_B_SCAN: begin
                if (!pick.found || r_cnt >= CW'(MV) || r_tail >= CW'(MV)) begin
                    n_state = S_B_POP;
                end else begin
                    n_visited = r_visited | (gdbo_pkg::t_row'(1) << pick.idx);
                    n_strobe  = 1'b1;
                    n_vout    = r_pend;
                    n_pend    = pick.idx;
                    n_cnt     = r_cnt + CW'(1);
                    st_we     = 1'b1;
                    st_waddr  = r_tail[VW-1:0];
                    st_wdata  = pick.idx;
                    n_tail    = r_tail + CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_st[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            r_st_q <= r_st[st_raddr];
        end
        if (adj_we) begin
            r_adj[adj_waddr] <= adj_wdata;
        end
        if (adj_re) begin
            r_adj_q  <= r_adj[adj_raddr];
            r_adj_ok <= r_row_ok[adj_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_num    <= FW'(32);
            r_row_ok <= '0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            r_cnt    <= '0;
            r_sp     <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_visited <= '0;
        end else begin
            r_state   <= n_state;
            r_strobe  <= n_strobe;
            r_last    <= n_last;
            r_cnt     <= n_cnt;
            r_sp      <= n_sp;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_visited <= n_visited;
            if (i_cfg_valid && o_cfg_ready) begin
                r_num <= i_cfg_num_vertices;
            end
            if (adj_we) begin
                r_row_ok[adj_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_from <= n_from;
        r_to   <= n_to;
        r_vout <= n_vout;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_strobe     = r_strobe;
    assign o_is_last    = r_last;
    assign o_vertex_out = FW'(r_vout) + FW'(1);

endmodule
